[rtl/tts_pkg.sv]
`default_nettype none

package tts_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned FIELD_W = 6;
   localparam int unsigned HUND_W  = 7;

   // result queue depth is two: output register plus skid entry
   localparam int unsigned QCNT_W  = 2;
   localparam logic [QCNT_W-1:0] QCNT_EMPTY = 2'd0;
   localparam logic [QCNT_W-1:0] QCNT_ONE   = 2'd1;
   localparam logic [QCNT_W-1:0] QCNT_FULL  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_FIVE  = 8'h35;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // match positions within HH:MM:SS.cc
   localparam logic [POS_W-1:0] POS_HOUR_TENS = 4'd0;
   localparam logic [POS_W-1:0] POS_HOUR_ONES = 4'd1;
   localparam logic [POS_W-1:0] POS_COLON_1   = 4'd2;
   localparam logic [POS_W-1:0] POS_MIN_TENS  = 4'd3;
   localparam logic [POS_W-1:0] POS_MIN_ONES  = 4'd4;
   localparam logic [POS_W-1:0] POS_COLON_2   = 4'd5;
   localparam logic [POS_W-1:0] POS_SEC_TENS  = 4'd6;
   localparam logic [POS_W-1:0] POS_SEC_ONES  = 4'd7;
   localparam logic [POS_W-1:0] POS_DOT       = 4'd8;
   localparam logic [POS_W-1:0] POS_HUND_TENS = 4'd9;
   localparam logic [POS_W-1:0] POS_HUND_ONES = 4'd10;

   typedef struct packed {
      logic [FIELD_W-1:0] hours;
      logic [FIELD_W-1:0] minutes;
      logic [FIELD_W-1:0] seconds;
      logic [HUND_W-1:0]  hundredths;
   } rsp_item_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_low_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_FIVE);
   endfunction

   // tens * 10 + ones, at most 99
   function automatic logic [HUND_W-1:0] tens_plus_ones(input logic [DIGIT_W-1:0] tens,
                                                      input logic [DIGIT_W-1:0] ones);
      logic [HUND_W-1:0] t;
      t = {3'b000, tens};
      return (t << 3) + (t << 1) + {3'b000, ones};
   endfunction

endpackage

`default_nettype wire

[rtl/timestamp_text_scanner.sv]
`default_nettype none

// Scans a text byte stream for timestamps of the exact form HH:MM:SS.cc and
// returns hours, minutes, seconds and hundredths for every complete match.
// One byte is taken per cycle while req_ready is high: the match position and
// the digits collected so far live in registers that update on every input
// transfer; the decode between them is a few compares and small adds. A byte
// that does not fit the current position is dropped and matching restarts
// with the next byte; a byte flagged end_of_text is matched normally and then
// clears any partial match. Results leave through a two-entry queue (output
// register plus skid entry), so req_ready drops only when both entries hold
// results that the consumer has not yet taken. A result appears on rsp_ at
// the earliest the cycle after the byte that completed it, later only when
// older results are still waiting for the consumer.
module timestamp_text_scanner (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [tts_pkg::CHAR_W-1:0]   req_char_byte,
   input  wire logic                         req_end_of_text,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [tts_pkg::FIELD_W-1:0]       rsp_hours,
   output logic [tts_pkg::FIELD_W-1:0]       rsp_minutes,
   output logic [tts_pkg::FIELD_W-1:0]       rsp_seconds,
   output logic [tts_pkg::HUND_W-1:0]        rsp_hundredths
);

   // match state
   logic [tts_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [tts_pkg::FIELD_W-1:0] hours_ff, hours_in;
   logic [tts_pkg::FIELD_W-1:0] minutes_ff, minutes_in;
   logic [tts_pkg::FIELD_W-1:0] seconds_ff, seconds_in;
   logic [tts_pkg::DIGIT_W-1:0] hund_tens_ff, hund_tens_in;

   // result queue
   logic [tts_pkg::QCNT_W-1:0]  count_ff, count_in;
   tts_pkg::rsp_item_type       head_ff, head_in;
   tts_pkg::rsp_item_type       skid_ff, skid_in;

   logic                        accept;
   logic                        pop;
   logic                        push;
   logic                        fits;
   logic [tts_pkg::CHAR_W-1:0]  diff;
   logic [tts_pkg::DIGIT_W-1:0] digit;
   logic [tts_pkg::HUND_W-1:0]  combined;
   logic [tts_pkg::HUND_W-1:0]  hund_full;
   tts_pkg::rsp_item_type       new_item;

   assign req_ready = (count_ff != tts_pkg::QCNT_FULL);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != tts_pkg::QCNT_EMPTY);
   assign pop       = rsp_valid && rsp_ready;

   // digit value of the byte; only meaningful once the range check passes
   assign diff  = req_char_byte - tts_pkg::CHAR_ZERO;
   assign digit = diff[tts_pkg::DIGIT_W-1:0];

   // ones digit joined to the tens digit held for the current field
   always_comb begin
      case (pos_ff)
         tts_pkg::POS_HOUR_ONES: combined = tts_pkg::tens_plus_ones(
                                    hours_ff[tts_pkg::DIGIT_W-1:0], digit);
         tts_pkg::POS_MIN_ONES:  combined = tts_pkg::tens_plus_ones(
                                    minutes_ff[tts_pkg::DIGIT_W-1:0], digit);
         default:                combined = tts_pkg::tens_plus_ones(
                                    seconds_ff[tts_pkg::DIGIT_W-1:0], digit);
      endcase
   end

   assign hund_full = tts_pkg::tens_plus_ones(hund_tens_ff, digit);

   // per-position character check and state update
   always_comb begin
      hours_in     = hours_ff;
      minutes_in   = minutes_ff;
      seconds_in   = seconds_ff;
      hund_tens_in = hund_tens_ff;
      fits         = 1'b0;
      case (pos_ff)
         tts_pkg::POS_HOUR_TENS: begin
            fits     = tts_pkg::is_low_digit(req_char_byte);
            hours_in = {2'b00, digit};
         end
         tts_pkg::POS_HOUR_ONES: begin
            fits     = tts_pkg::is_digit(req_char_byte);
            hours_in = combined[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_COLON_1: fits = (req_char_byte == tts_pkg::CHAR_COLON);
         tts_pkg::POS_MIN_TENS: begin
            fits       = tts_pkg::is_low_digit(req_char_byte);
            minutes_in = {2'b00, digit};
         end
         tts_pkg::POS_MIN_ONES: begin
            fits       = tts_pkg::is_digit(req_char_byte);
            minutes_in = combined[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_COLON_2: fits = (req_char_byte == tts_pkg::CHAR_COLON);
         tts_pkg::POS_SEC_TENS: begin
            fits       = tts_pkg::is_low_digit(req_char_byte);
            seconds_in = {2'b00, digit};
         end
         tts_pkg::POS_SEC_ONES: begin
            fits       = tts_pkg::is_digit(req_char_byte);
            seconds_in = combined[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_DOT: fits = (req_char_byte == tts_pkg::CHAR_DOT);
         tts_pkg::POS_HUND_TENS: begin
            fits         = tts_pkg::is_digit(req_char_byte);
            hund_tens_in = digit;
         end
         tts_pkg::POS_HUND_ONES: fits = tts_pkg::is_digit(req_char_byte);
         default: fits = 1'b0;
      endcase

      // a mismatch keeps the held digits; they are rewritten before next use
      if (!fits) begin
         hours_in     = hours_ff;
         minutes_in   = minutes_ff;
         seconds_in   = seconds_ff;
         hund_tens_in = hund_tens_ff;
         pos_in       = tts_pkg::POS_HOUR_TENS;
      end else if (pos_ff == tts_pkg::POS_HUND_ONES) begin
         pos_in = tts_pkg::POS_HOUR_TENS;
      end else begin
         pos_in = pos_ff + 4'd1;
      end

      // last byte of the text drops any partial match
      if (req_end_of_text) begin
         pos_in       = tts_pkg::POS_HOUR_TENS;
         hours_in     = '0;
         minutes_in   = '0;
         seconds_in   = '0;
         hund_tens_in = '0;
      end
   end

   // eleventh matching byte completes a timestamp
   assign push = accept && fits && (pos_ff == tts_pkg::POS_HUND_ONES);

   assign new_item.hours      = hours_ff;
   assign new_item.minutes    = minutes_ff;
   assign new_item.seconds    = seconds_ff;
   assign new_item.hundredths = hund_full;

   // two-entry result queue: head drives the rsp_ ports, skid catches a
   // result produced while the head is stalled
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         tts_pkg::QCNT_EMPTY: begin
            if (push) begin
               head_in  = new_item;
               count_in = tts_pkg::QCNT_ONE;
            end
         end
         tts_pkg::QCNT_ONE: begin
            if (push && pop) begin
               head_in = new_item;
            end else if (push) begin
               skid_in  = new_item;
               count_in = tts_pkg::QCNT_FULL;
            end else if (pop) begin
               count_in = tts_pkg::QCNT_EMPTY;
            end
         end
         tts_pkg::QCNT_FULL: begin
            // no transfer in while full
            if (pop) begin
               head_in  = skid_ff;
               count_in = tts_pkg::QCNT_ONE;
            end
         end
         default: count_in = tts_pkg::QCNT_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= tts_pkg::POS_HOUR_TENS;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
         hund_tens_ff <= '0;
         count_ff     <= tts_pkg::QCNT_EMPTY;
      end else begin
         if (accept) begin
            pos_ff       <= pos_in;
            hours_ff     <= hours_in;
            minutes_ff   <= minutes_in;
            seconds_ff   <= seconds_in;
            hund_tens_ff <= hund_tens_in;
         end
         count_ff <= count_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_hours      = head_ff.hours;
   assign rsp_minutes    = head_ff.minutes;
   assign rsp_seconds    = head_ff.seconds;
   assign rsp_hundredths = head_ff.hundredths;

   // position never passes the last character of a timestamp
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= tts_pkg::POS_HUND_ONES)
      else $error("match position out of range");

   // queue never holds more than two results
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tts_pkg::QCNT_FULL)
      else $error("result queue count out of range");

   // last byte always leaves the scanner at the start of a match
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_text |=> pos_ff == tts_pkg::POS_HOUR_TENS)
      else $error("partial match survived last byte");

   // a completed timestamp without a pop grows the queue by one
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("completed timestamp lost");

   // completing a match sends the position back to the start
   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      push |=> pos_ff == tts_pkg::POS_HOUR_TENS)
      else $error("position not restarted after match");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;

   // how a table row gets its expected outcome
   typedef enum logic {
      CHECK_PREDICTED,
      CHECK_TYPED
   } check_kind_type;

   typedef struct packed {
      logic [tts_pkg::CHAR_W-1:0] ch;
      logic                       last;
      check_kind_type             kind;
      tts_pkg::rsp_item_type      stamp;
   } scan_row_type;

   localparam int unsigned DIRECTED_ROWS = 32;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned DRAIN_CYCLES  = 8;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [tts_pkg::CHAR_W-1:0]   req_char_byte = '0;
   logic                         req_end_of_text = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [tts_pkg::FIELD_W-1:0]  rsp_hours;
   logic [tts_pkg::FIELD_W-1:0]  rsp_minutes;
   logic [tts_pkg::FIELD_W-1:0]  rsp_seconds;
   logic [tts_pkg::HUND_W-1:0]   rsp_hundredths;

   timestamp_text_scanner dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_byte   (req_char_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hours       (rsp_hours),
      .rsp_minutes     (rsp_minutes),
      .rsp_seconds     (rsp_seconds),
      .rsp_hundredths  (rsp_hundredths)
   );

   always #10 clock = ~clock;

   // scanner state as the testbench sees it, reset values
   logic [tts_pkg::POS_W-1:0]   scan_pos      = tts_pkg::POS_HOUR_TENS;
   logic [tts_pkg::FIELD_W-1:0] hours_acc     = '0;
   logic [tts_pkg::FIELD_W-1:0] minutes_acc   = '0;
   logic [tts_pkg::FIELD_W-1:0] seconds_acc   = '0;
   logic [tts_pkg::DIGIT_W-1:0] hund_tens_acc = '0;

   tts_pkg::rsp_item_type pending_stamps[$];
   int           error_count   = 0;
   int           bytes_sent    = 0;
   bit           calm          = 1'b0;
   bit           sender_steady = 1'b0;
   bit           squeeze_on    = 1'b0;
   bit           squeeze_done  = 1'b0;
   string        scan_alphabet = "0123456789:.";

   // directed text: both extreme stamps, stray bytes after them, a broken
   // separator and a text that ends in the middle of a stamp
   scan_row_type directed_rows [DIRECTED_ROWS] = '{
      // all-zero stamp, closed by end of text
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{":", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{":", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{".", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b1, CHECK_TYPED, '{6'd0, 6'd0, 6'd0, 7'd0}},
      // largest stamp, text keeps going
      '{"5", 1'b0, CHECK_PREDICTED, '0},
      '{"9", 1'b0, CHECK_PREDICTED, '0},
      '{":", 1'b0, CHECK_PREDICTED, '0},
      '{"5", 1'b0, CHECK_PREDICTED, '0},
      '{"9", 1'b0, CHECK_PREDICTED, '0},
      '{":", 1'b0, CHECK_PREDICTED, '0},
      '{"5", 1'b0, CHECK_PREDICTED, '0},
      '{"9", 1'b0, CHECK_PREDICTED, '0},
      '{".", 1'b0, CHECK_PREDICTED, '0},
      '{"9", 1'b0, CHECK_PREDICTED, '0},
      '{"9", 1'b0, CHECK_TYPED, '{6'd59, 6'd59, 6'd59, 7'd99}},
      // bytes that cannot open a stamp
      '{8'hFF, 1'b0, CHECK_PREDICTED, '0},
      '{8'h00, 1'b0, CHECK_PREDICTED, '0},
      '{"6", 1'b0, CHECK_PREDICTED, '0},
      // dot where a colon belongs is dropped
      '{"1", 1'b0, CHECK_PREDICTED, '0},
      '{"2", 1'b0, CHECK_PREDICTED, '0},
      '{".", 1'b0, CHECK_PREDICTED, '0},
      // partial stamp thrown away at end of text
      '{"4", 1'b0, CHECK_PREDICTED, '0},
      '{"5", 1'b0, CHECK_PREDICTED, '0},
      '{":", 1'b0, CHECK_PREDICTED, '0},
      '{"0", 1'b1, CHECK_PREDICTED, '0}
   };

   // advance the scanner by one byte, returns 1 when a stamp completes
   function automatic bit scan_byte(input logic [tts_pkg::CHAR_W-1:0] c, input bit last,
                                    output tts_pkg::rsp_item_type stamp);
      logic [tts_pkg::CHAR_W-1:0] d;
      logic [tts_pkg::CHAR_W-1:0] sum;
      bit dec;
      bit low;
      bit ok;
      bit hit;
      d     = c - tts_pkg::CHAR_ZERO;
      sum   = '0;
      dec   = (c >= tts_pkg::CHAR_ZERO) && (c <= tts_pkg::CHAR_NINE);
      low   = (c >= tts_pkg::CHAR_ZERO) && (c <= tts_pkg::CHAR_FIVE);
      ok    = 1'b0;
      hit   = 1'b0;
      stamp = '0;
      case (scan_pos)
         tts_pkg::POS_HOUR_TENS: begin
            ok = low;
            if (ok) hours_acc = d[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_HOUR_ONES: begin
            ok  = dec;
            sum = 8'(hours_acc) * 8'd10 + d;
            if (ok) hours_acc = sum[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_MIN_TENS: begin
            ok = low;
            if (ok) minutes_acc = d[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_MIN_ONES: begin
            ok  = dec;
            sum = 8'(minutes_acc) * 8'd10 + d;
            if (ok) minutes_acc = sum[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_SEC_TENS: begin
            ok = low;
            if (ok) seconds_acc = d[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_SEC_ONES: begin
            ok  = dec;
            sum = 8'(seconds_acc) * 8'd10 + d;
            if (ok) seconds_acc = sum[tts_pkg::FIELD_W-1:0];
         end
         tts_pkg::POS_COLON_1, tts_pkg::POS_COLON_2: ok = (c == tts_pkg::CHAR_COLON);
         tts_pkg::POS_DOT: ok = (c == tts_pkg::CHAR_DOT);
         tts_pkg::POS_HUND_TENS: begin
            ok = dec;
            if (ok) hund_tens_acc = d[tts_pkg::DIGIT_W-1:0];
         end
         tts_pkg::POS_HUND_ONES: begin
            ok  = dec;
            sum = 8'(hund_tens_acc) * 8'd10 + d;
         end
         default: ok = 1'b0;
      endcase

      // a misfit byte is consumed, no retry as a new start
      if (!ok) begin
         scan_pos = tts_pkg::POS_HOUR_TENS;
      end else if (scan_pos == tts_pkg::POS_HUND_ONES) begin
         stamp.hours      = hours_acc;
         stamp.minutes    = minutes_acc;
         stamp.seconds    = seconds_acc;
         stamp.hundredths = sum[tts_pkg::HUND_W-1:0];
         hit              = 1'b1;
         scan_pos         = tts_pkg::POS_HOUR_TENS;
      end else begin
         scan_pos = scan_pos + 1'b1;
      end

      // end of text wipes any partial stamp
      if (last) begin
         scan_pos      = tts_pkg::POS_HOUR_TENS;
         hours_acc     = '0;
         minutes_acc   = '0;
         seconds_acc   = '0;
         hund_tens_acc = '0;
      end
      return hit;
   endfunction

   // a byte that fits position p of a stamp
   function automatic logic [tts_pkg::CHAR_W-1:0] stamp_char(input int p);
      case (p)
         tts_pkg::POS_HOUR_TENS, tts_pkg::POS_MIN_TENS, tts_pkg::POS_SEC_TENS:
            return tts_pkg::CHAR_ZERO + 8'($urandom_range(0, 5));
         tts_pkg::POS_COLON_1, tts_pkg::POS_COLON_2: return tts_pkg::CHAR_COLON;
         tts_pkg::POS_DOT: return tts_pkg::CHAR_DOT;
         default: return tts_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   // half the time a stamp-like character, otherwise any byte
   function automatic logic [tts_pkg::CHAR_W-1:0] noise_char();
      if ($urandom_range(0, 1) == 0)
         return scan_alphabet[$urandom_range(0, scan_alphabet.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one byte, wait for its transfer, then log what it should produce
   task automatic push_byte(input logic [tts_pkg::CHAR_W-1:0] c, input bit last,
                            input check_kind_type kind = CHECK_PREDICTED,
                            input tts_pkg::rsp_item_type table_stamp = '0);
      tts_pkg::rsp_item_type stamp;
      bit hit;
      // random sender idling, off in steady and calm stretches
      if (!calm && !sender_steady && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_text <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      hit = scan_byte(c, last, stamp);
      if (kind == CHECK_TYPED)
         pending_stamps.push_back(table_stamp);
      else if (hit)
         pending_stamps.push_back(stamp);
   endtask

   // one stamp, optionally with one spoiled byte and an early end of text
   task automatic send_stamp(input int bad_pos, input int last_pos);
      logic [tts_pkg::CHAR_W-1:0] c;
      for (int p = tts_pkg::POS_HOUR_TENS; p <= tts_pkg::POS_HUND_ONES; p++) begin
         c = (p == bad_pos) ? noise_char() : stamp_char(p);
         push_byte(c, p == last_pos);
         if (p == last_pos) break;
      end
   endtask

   // mostly stamps with random digits, some broken, some loose noise
   task automatic send_random_text();
      int bad_pos;
      int last_pos;
      bad_pos  = -1;
      last_pos = -1;
      if ($urandom_range(0, 9) < 8) begin
         if ($urandom_range(0, 3) == 0)
            bad_pos = $urandom_range(0, tts_pkg::POS_HUND_ONES);
         if ($urandom_range(0, 7) == 0)
            last_pos = $urandom_range(0, tts_pkg::POS_HUND_ONES);
         send_stamp(bad_pos, last_pos);
      end else begin
         repeat ($urandom_range(1, 6)) push_byte(noise_char(), $urandom_range(0, 15) == 0);
      end
   endtask

   // park the sender until every stamp in flight has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_stamps.size() != 0);
   endtask

   // byte stream
   initial begin : byte_feeder
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         push_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].kind,
                   directed_rows[i].stamp);
      drain_results();

      while (bytes_sent < 900) send_random_text();

      // clean stamps back to back while the consumer holds off
      sender_steady = 1'b1;
      squeeze_on    = 1'b1;
      repeat (12) send_stamp(-1, -1);
      sender_steady = 1'b0;
      drain_results();

      while (bytes_sent < 1800) send_random_text();

      // closing stretch without idling on either side
      calm = 1'b1;
      while (bytes_sent < 2050) send_random_text();

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_stamps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // consumer: random ready runs and stall bursts, one long hold
   initial begin : stamp_sink
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_on && !squeeze_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   // compare every result transfer against the oldest pending stamp
   always @(posedge clock) begin : stamp_check
      tts_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stamps.size() == 0) begin
            $error("unexpected timestamp %0d:%0d:%0d.%0d", rsp_hours, rsp_minutes,
                   rsp_seconds, rsp_hundredths);
            error_count++;
         end else begin
            want = pending_stamps.pop_front();
            if (rsp_hours !== want.hours) begin
               $error("hours: expected %0d, got %0d", want.hours, rsp_hours);
               error_count++;
            end
            if (rsp_minutes !== want.minutes) begin
               $error("minutes: expected %0d, got %0d", want.minutes, rsp_minutes);
               error_count++;
            end
            if (rsp_seconds !== want.seconds) begin
               $error("seconds: expected %0d, got %0d", want.seconds, rsp_seconds);
               error_count++;
            end
            if (rsp_hundredths !== want.hundredths) begin
               $error("hundredths: expected %0d, got %0d", want.hundredths, rsp_hundredths);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin : run_limit
      #(20 * 400_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
